>>> sv/ctre_pkg.sv
// Types and codes shared by the connection table retransmit engine.
`default_nettype none
package ctre_pkg;

  localparam logic [3:0] OP_CREATE  = 4'd0;
  localparam logic [3:0] OP_RM_IDX  = 4'd1;
  localparam logic [3:0] OP_RM_ADDR = 4'd2;
  localparam logic [3:0] OP_FIND    = 4'd3;
  localparam logic [3:0] OP_TOUCH   = 4'd4;
  localparam logic [3:0] OP_SENT    = 4'd5;
  localparam logic [3:0] OP_RESET   = 4'd6;
  localparam logic [3:0] OP_DUP     = 4'd7;
  localparam logic [3:0] OP_ARM     = 4'd8;
  localparam logic [3:0] OP_IDLE_SW = 4'd9;
  localparam logic [3:0] OP_RETX_SW = 4'd10;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EXISTS   = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_BADADDR  = 3'd4;

  localparam logic [1:0] REG_MAX_CONN = 2'd0;
  localparam logic [1:0] REG_IDLE_TO  = 2'd1;
  localparam logic [1:0] REG_INIT_RTO = 2'd2;
  localparam logic [1:0] REG_MAX_RTO  = 2'd3;

  localparam logic [4:0] NO_RX_SEQ = 5'd16;
  localparam logic [7:0] CNT_MAX   = 8'hFF;

  typedef struct packed {
    logic [3:0]  op;
    logic [15:0] remote_address;
    logic [2:0]  conn_index;
    logic [3:0]  seq_number;
    logic [7:0]  retry_limit;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] result_index;
    logic       hit;
    logic       duplicate;
    logic [7:0] retry_count;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] peer_address;
    logic [3:0]  tx_sequence;
    logic [3:0]  expected_rx_sequence;
    logic [4:0]  last_rx_sequence;
    logic [7:0]  entry_retry_limit;
    logic [31:0] activity_time;
    logic        retx_pending;
    logic [7:0]  retx_count;
    logic [31:0] last_tx_time;
    logic [31:0] retx_timeout;
  } entry_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_EX   = 6'b000100,
    S_MOD  = 6'b001000,
    S_FREE = 6'b010000,
    S_WAIT = 6'b100000
  } state_t;

  function automatic out_item_t mk_out(logic [2:0] status, logic [2:0] idx, logic hit,
                                       logic dup, logic [7:0] cnt, logic last);
    out_item_t o;
    o.status       = status;
    o.result_index = hit ? idx : 3'd0;
    o.hit          = hit;
    o.duplicate    = dup;
    o.retry_count  = cnt;
    o.last         = last;
    return o;
  endfunction

endpackage
`default_nettype wire

>>> sv/connection_table_retransmit_engine_top.sv
// Connection table with retransmit backoff: sequencer, entry memory, shared time compare.
//
//   channel | ports                          | role
//   in      | in_valid, in_stall, in_item    | one table op per item
//   out     | out_valid, out_stall, out_item | one or more results per op
//   cfg     | cfg_wr_en, cfg_index, cfg_wdata| register writes
//
// Index ops read the entry, then update it and report; address ops and sweeps walk up to
// TABLE_SLOTS entries, each with a registered memory read, then one shared subtract/compare;
// each sweep hit waits for its result to be taken. Create adds a second pass:
// repeated subtraction reducing the rotating pointer, then a free search of up to the in-use
// slot count.
// Synchronous reset clears valid bits and pointer and loads register defaults; entry data is not reset.
// in_stall stays high from accept until the last result is taken; out_stall holds out_item.
`default_nettype none
module connection_table_retransmit_engine_top #(
  parameter int TABLE_SLOTS = 8
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  ctre_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  wire                  out_stall,
  output ctre_pkg::out_item_t  out_item,
  input  wire                  cfg_wr_en,
  input  wire  [1:0]           cfg_index,
  input  wire  [31:0]          cfg_wdata
);

  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_SLOTS - 1);

  logic [3:0]  max_conn_r;
  logic [31:0] idle_to_r, init_rto_r, max_rto_r;

  ctre_pkg::state_t    state_r, state_nxt;
  ctre_pkg::in_item_t  in_q_r, in_q_nxt;
  ctre_pkg::out_item_t out_r, out_nxt;
  ctre_pkg::entry_t    mem [TABLE_SLOTS];
  ctre_pkg::entry_t    rd_q_r, wr_data;
  logic                out_valid_r, out_valid_nxt;
  logic [TABLE_SLOTS-1:0] valid_r, valid_nxt;
  logic [IW-1:0]       ptr_r, ptr_nxt, rem_r, rem_nxt, next_slot_r, next_slot_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt, j_r, j_nxt, m;
  logic                found_r, found_nxt;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;

  logic [31:0] cmp_a, cmp_b, elapsed;
  logic        time_due;
  logic [32:0] dbl;
  logic        vld, match;
  ctre_pkg::entry_t e;

  always_comb begin
    if (max_conn_r == 4'd0) m = CW'(1);
    else if (32'(max_conn_r) > TABLE_SLOTS) m = CW'(TABLE_SLOTS);
    else m = CW'(max_conn_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_conn_r <= 4'd8;
      idle_to_r  <= 32'd6000;
      init_rto_r <= 32'd3000;
      max_rto_r  <= 32'd6000;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ctre_pkg::REG_MAX_CONN: max_conn_r <= cfg_wdata[3:0];
        ctre_pkg::REG_IDLE_TO:  idle_to_r  <= cfg_wdata;
        ctre_pkg::REG_INIT_RTO: init_rto_r <= cfg_wdata;
        ctre_pkg::REG_MAX_RTO:  max_rto_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_q_r <= mem[ptr_r];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  assign vld   = valid_r[ptr_r];
  assign e     = rd_q_r;
  assign match = vld && (e.peer_address == in_q_r.remote_address);

  // shared elapsed-time compare
  always_comb begin
    cmp_a = e.activity_time;
    cmp_b = idle_to_r;
    if (in_q_r.op == ctre_pkg::OP_RETX_SW) begin
      cmp_a = e.last_tx_time;
      cmp_b = e.retx_timeout;
    end
  end
  assign elapsed  = in_q_r.time_ms - cmp_a;
  assign time_due = elapsed >= cmp_b;
  assign dbl      = {e.retx_timeout, 1'b0};

  always_comb begin
    state_nxt     = state_r;
    in_q_nxt      = in_q_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    valid_nxt     = valid_r;
    ptr_nxt       = ptr_r;
    rem_nxt       = rem_r;
    next_slot_nxt = next_slot_r;
    cnt_nxt       = cnt_r;
    j_nxt         = j_r;
    found_nxt     = found_r;
    wr_en         = 1'b0;
    wr_addr       = ptr_r;
    wr_data       = e;

    unique case (state_r)
      ctre_pkg::S_IDLE: begin
        if (in_valid) begin
          in_q_nxt  = in_item;
          ptr_nxt   = '0;
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = ctre_pkg::S_RD;
          unique case (in_item.op)
            ctre_pkg::OP_CREATE: begin
              if (in_item.remote_address == 16'd0) begin
                out_nxt = ctre_pkg::mk_out(ctre_pkg::ST_BADADDR, 3'd0, 1'b0, 1'b0, 8'd0, 1'b1);
                out_valid_nxt = 1'b1;
                state_nxt = ctre_pkg::S_WAIT;
              end
            end
            ctre_pkg::OP_RM_ADDR, ctre_pkg::OP_FIND,
            ctre_pkg::OP_IDLE_SW, ctre_pkg::OP_RETX_SW: ;
            ctre_pkg::OP_RM_IDX, ctre_pkg::OP_TOUCH, ctre_pkg::OP_SENT,
            ctre_pkg::OP_RESET, ctre_pkg::OP_DUP, ctre_pkg::OP_ARM: begin
              if (32'(in_item.conn_index) >= TABLE_SLOTS ||
                  !valid_r[IW'(in_item.conn_index)]) begin
                out_nxt = ctre_pkg::mk_out(ctre_pkg::ST_NOTFOUND, 3'd0, 1'b0, 1'b0, 8'd0, 1'b1);
                out_valid_nxt = 1'b1;
                state_nxt = ctre_pkg::S_WAIT;
              end else begin
                ptr_nxt = IW'(in_item.conn_index);
              end
            end
            default: begin
              out_nxt = ctre_pkg::mk_out(ctre_pkg::ST_NOTFOUND, 3'd0, 1'b0, 1'b0, 8'd0, 1'b1);
              out_valid_nxt = 1'b1;
              state_nxt = ctre_pkg::S_WAIT;
            end
          endcase
        end
      end

      ctre_pkg::S_RD: state_nxt = ctre_pkg::S_EX;

      ctre_pkg::S_EX: begin
        state_nxt = ctre_pkg::S_RD;
        unique case (in_q_r.op)
          ctre_pkg::OP_CREATE: begin
            cnt_nxt   = cnt_r + CW'(vld);
            found_nxt = found_r | match;
            if (ptr_r == LAST_SLOT) begin
              if (cnt_nxt >= m) begin
                out_nxt = ctre_pkg::mk_out(ctre_pkg::ST_FULL, 3'd0, 1'b0, 1'b0, 8'd0, 1'b1);
                out_valid_nxt = 1'b1;
                state_nxt = ctre_pkg::S_WAIT;
              end else if (found_nxt) begin
                out_nxt = ctre_pkg::mk_out(ctre_pkg::ST_EXISTS, 3'd0, 1'b0, 1'b0, 8'd0, 1'b1);
                out_valid_nxt = 1'b1;
                state_nxt = ctre_pkg::S_WAIT;
              end else begin
                rem_nxt   = next_slot_r;
                state_nxt = ctre_pkg::S_MOD;
              end
            end else begin
              ptr_nxt = ptr_r + IW'(1);
            end
          end
          ctre_pkg::OP_RM_ADDR, ctre_pkg::OP_FIND: begin
            if (match) begin
              if (in_q_r.op == ctre_pkg::OP_RM_ADDR) valid_nxt[ptr_r] = 1'b0;
              out_nxt = ctre_pkg::mk_out(ctre_pkg::ST_OK, 3'(ptr_r), 1'b1, 1'b0, 8'd0, 1'b1);
              out_valid_nxt = 1'b1;
              state_nxt = ctre_pkg::S_WAIT;
            end else if (ptr_r == LAST_SLOT) begin
              out_nxt = ctre_pkg::mk_out(ctre_pkg::ST_NOTFOUND, 3'd0, 1'b0, 1'b0, 8'd0, 1'b1);
              out_valid_nxt = 1'b1;
              state_nxt = ctre_pkg::S_WAIT;
            end else begin
              ptr_nxt = ptr_r + IW'(1);
            end
          end
          ctre_pkg::OP_IDLE_SW, ctre_pkg::OP_RETX_SW: begin
            if (in_q_r.op == ctre_pkg::OP_IDLE_SW && vld && time_due) begin
              valid_nxt[ptr_r] = 1'b0;
              out_nxt = ctre_pkg::mk_out(ctre_pkg::ST_OK, 3'(ptr_r), 1'b1, 1'b0, 8'd0, 1'b0);
              out_valid_nxt = 1'b1;
              state_nxt = ctre_pkg::S_WAIT;
            end else if (in_q_r.op == ctre_pkg::OP_RETX_SW && vld && e.retx_pending &&
                         time_due && (e.retx_count < e.entry_retry_limit)) begin
              wr_en = 1'b1;
              wr_data.retx_timeout = (dbl <= {1'b0, max_rto_r}) ? dbl[31:0] : max_rto_r;
              out_nxt = ctre_pkg::mk_out(ctre_pkg::ST_OK, 3'(ptr_r), 1'b1, 1'b0, 8'd0, 1'b0);
              out_valid_nxt = 1'b1;
              state_nxt = ctre_pkg::S_WAIT;
            end else begin
              if (in_q_r.op == ctre_pkg::OP_RETX_SW && vld && e.retx_pending && time_due) begin
                wr_en = 1'b1;
                wr_data.retx_pending = 1'b0;
                wr_data.retx_count   = 8'd0;
                wr_data.last_tx_time = 32'd0;
                wr_data.retx_timeout = init_rto_r;
              end
              if (ptr_r == LAST_SLOT) begin
                out_nxt = ctre_pkg::mk_out(ctre_pkg::ST_OK, 3'd0, 1'b0, 1'b0, 8'd0, 1'b1);
                out_valid_nxt = 1'b1;
                state_nxt = ctre_pkg::S_WAIT;
              end else begin
                ptr_nxt = ptr_r + IW'(1);
              end
            end
          end
          default: begin
            out_nxt = ctre_pkg::mk_out(ctre_pkg::ST_OK, 3'(ptr_r), 1'b1, 1'b0, 8'd0, 1'b1);
            out_valid_nxt = 1'b1;
            state_nxt = ctre_pkg::S_WAIT;
            wr_en = 1'b1;
            unique case (in_q_r.op)
              ctre_pkg::OP_RM_IDX: begin
                wr_en = 1'b0;
                valid_nxt[ptr_r] = 1'b0;
              end
              ctre_pkg::OP_TOUCH: wr_data.activity_time = in_q_r.time_ms;
              ctre_pkg::OP_SENT: begin
                if (e.retx_count < ctre_pkg::CNT_MAX) wr_data.retx_count = e.retx_count + 8'd1;
                wr_data.last_tx_time = 32'd0;
                out_nxt.retry_count = wr_data.retx_count;
              end
              ctre_pkg::OP_RESET: begin
                wr_data.retx_pending = 1'b0;
                wr_data.retx_count   = 8'd0;
                wr_data.last_tx_time = 32'd0;
                wr_data.retx_timeout = init_rto_r;
              end
              ctre_pkg::OP_DUP: begin
                if (e.last_rx_sequence == {1'b0, in_q_r.seq_number}) begin
                  out_nxt.duplicate = 1'b1;
                  wr_en = 1'b0;
                end else begin
                  wr_data.last_rx_sequence = {1'b0, in_q_r.seq_number};
                end
              end
              default: begin
                wr_data.retx_pending = 1'b1;
                wr_data.last_tx_time = in_q_r.time_ms;
              end
            endcase
          end
        endcase
      end

      ctre_pkg::S_MOD: begin
        if (CW'(rem_r) >= m) begin
          rem_nxt = rem_r - IW'(m);
        end else begin
          ptr_nxt   = rem_r;
          j_nxt     = '0;
          state_nxt = ctre_pkg::S_FREE;
        end
      end

      ctre_pkg::S_FREE: begin
        if (!valid_r[ptr_r]) begin
          valid_nxt[ptr_r] = 1'b1;
          wr_en   = 1'b1;
          wr_data.peer_address         = in_q_r.remote_address;
          wr_data.tx_sequence          = in_q_r.seq_number;
          wr_data.expected_rx_sequence = in_q_r.seq_number;
          wr_data.last_rx_sequence     = ctre_pkg::NO_RX_SEQ;
          wr_data.entry_retry_limit    = in_q_r.retry_limit;
          wr_data.activity_time        = 32'd0;
          wr_data.retx_pending         = 1'b0;
          wr_data.retx_count           = 8'd0;
          wr_data.last_tx_time         = 32'd0;
          wr_data.retx_timeout         = init_rto_r;
          next_slot_nxt = (CW'(ptr_r) + CW'(1) == m) ? '0 : ptr_r + IW'(1);
          out_nxt = ctre_pkg::mk_out(ctre_pkg::ST_OK, 3'(ptr_r), 1'b1, 1'b0, 8'd0, 1'b1);
          out_valid_nxt = 1'b1;
          state_nxt = ctre_pkg::S_WAIT;
        end else if (j_r + CW'(1) == m) begin
          out_nxt = ctre_pkg::mk_out(ctre_pkg::ST_FULL, 3'd0, 1'b0, 1'b0, 8'd0, 1'b1);
          out_valid_nxt = 1'b1;
          state_nxt = ctre_pkg::S_WAIT;
        end else begin
          j_nxt   = j_r + CW'(1);
          ptr_nxt = (CW'(ptr_r) + CW'(1) == m) ? '0 : ptr_r + IW'(1);
        end
      end

      ctre_pkg::S_WAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_r.last) begin
            state_nxt = ctre_pkg::S_IDLE;
          end else if (ptr_r == LAST_SLOT) begin
            out_nxt = ctre_pkg::mk_out(ctre_pkg::ST_OK, 3'd0, 1'b0, 1'b0, 8'd0, 1'b1);
            out_valid_nxt = 1'b1;
          end else begin
            ptr_nxt   = ptr_r + IW'(1);
            state_nxt = ctre_pkg::S_RD;
          end
        end
      end

      default: state_nxt = ctre_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ctre_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      next_slot_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      next_slot_r <= next_slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_q_r  <= in_q_nxt;
    out_r   <= out_nxt;
    ptr_r   <= ptr_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    j_r     <= j_nxt;
    found_r <= found_nxt;
  end

  assign in_stall  = (state_r != ctre_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

>>> sv/ctre_checker.sv
// Port-level checks for the connection table retransmit engine, with bind.
`default_nettype none
module ctre_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_stall,
  input wire                 out_valid,
  input wire                 out_stall,
  input ctre_pkg::out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted a second item while busy");

  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.hit |-> out_item.status == ctre_pkg::ST_OK)
    else $error("hit with error status");

  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.hit |-> out_item.result_index == 3'd0)
    else $error("index without hit");

  a_dup_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.duplicate |-> out_item.last && out_item.hit)
    else $error("duplicate flag outside a single result");

endmodule

bind connection_table_retransmit_engine_top ctre_checker u_ctre_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the connection table retransmit engine.
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int SLOTS = 8;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ctre_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ctre_pkg::out_item_t out_item;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  connection_table_retransmit_engine_top #(.TABLE_SLOTS(SLOTS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [3:0]  cfg_max_conn;
  logic [31:0] cfg_idle_to, cfg_init_rto, cfg_max_rto;
  logic        tbl_valid [SLOTS];
  ctre_pkg::entry_t tbl [SLOTS];
  logic [2:0]  next_slot;

  ctre_pkg::in_item_t  pending_items [$];
  ctre_pkg::out_item_t expected_results [$];
  int  error_count = 0;
  int  watchdog = 0;
  bit  in_taken = 0;
  bit  hold_off = 0;
  bit  hold_done = 0;
  int  hold_count = 0;
  bit  stall_pattern_on = 1;
  bit  gaps_on = 1;
  int  burst_left = 0;
  int  gap_left = 0;
  logic [15:0] known_addrs [$];

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input ctre_pkg::out_item_t got,
                                 input ctre_pkg::out_item_t exp);
    error_count++;
    $display("mismatch %s: got %p exp %p at %0t", what, got, exp, $realtime);
  endtask

  function automatic void expect_result(ctre_pkg::out_item_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic int slots_in_use();
    int m;
    m = cfg_max_conn;
    if (m == 0) m = 1;
    if (m > SLOTS) m = SLOTS;
    return m;
  endfunction

  function automatic ctre_pkg::out_item_t result_of(logic [2:0] st, logic [2:0] idx, logic h,
                                                    logic d, logic [7:0] c, logic l);
    ctre_pkg::out_item_t r;
    r.status = st;
    r.result_index = h ? idx : 3'd0;
    r.hit = h;
    r.duplicate = d;
    r.retry_count = c;
    r.last = l;
    return r;
  endfunction

  function automatic void clear_retx(int s);
    tbl[s].retx_pending = 1'b0;
    tbl[s].retx_count = '0;
    tbl[s].last_tx_time = '0;
    tbl[s].retx_timeout = cfg_init_rto;
  endfunction

  function automatic int find_addr(logic [15:0] a);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_valid[i] && tbl[i].peer_address == a) return i;
    return -1;
  endfunction

  function automatic void write_reg_model(logic [1:0] idx, logic [31:0] v);
    case (idx)
      ctre_pkg::REG_MAX_CONN: cfg_max_conn = v[3:0];
      ctre_pkg::REG_IDLE_TO:  cfg_idle_to = v;
      ctre_pkg::REG_INIT_RTO: cfg_init_rto = v;
      default:                cfg_max_rto = v;
    endcase
  endfunction

  function automatic void predict_table_op(ctre_pkg::in_item_t it);
    int s, m, cnt, c;
    logic [7:0] rc;
    logic d;
    logic [63:0] dbl;
    rc = '0;
    d = 1'b0;
    case (it.op)
      ctre_pkg::OP_CREATE: begin
        if (it.remote_address == 0) begin
          expect_result(result_of(ctre_pkg::ST_BADADDR, 0, 0, 0, 0, 1));
          return;
        end
        m = slots_in_use();
        cnt = 0;
        for (int i = 0; i < SLOTS; i++) cnt += tbl_valid[i];
        if (cnt >= m) begin
          expect_result(result_of(ctre_pkg::ST_FULL, 0, 0, 0, 0, 1));
          return;
        end
        if (find_addr(it.remote_address) >= 0) begin
          expect_result(result_of(ctre_pkg::ST_EXISTS, 0, 0, 0, 0, 1));
          return;
        end
        s = -1;
        for (int j = 0; j < m; j++) begin
          c = (next_slot % m + j) % m;
          if (!tbl_valid[c]) begin
            s = c;
            break;
          end
        end
        if (s < 0) begin
          expect_result(result_of(ctre_pkg::ST_FULL, 0, 0, 0, 0, 1));
          return;
        end
        tbl_valid[s] = 1'b1;
        tbl[s].peer_address = it.remote_address;
        tbl[s].tx_sequence = it.seq_number;
        tbl[s].expected_rx_sequence = it.seq_number;
        tbl[s].last_rx_sequence = ctre_pkg::NO_RX_SEQ;
        tbl[s].entry_retry_limit = it.retry_limit;
        tbl[s].activity_time = '0;
        clear_retx(s);
        next_slot = 3'((s + 1) % m);
        expect_result(result_of(ctre_pkg::ST_OK, 3'(s), 1, 0, 0, 1));
      end
      ctre_pkg::OP_RM_IDX, ctre_pkg::OP_RM_ADDR, ctre_pkg::OP_FIND, ctre_pkg::OP_TOUCH,
      ctre_pkg::OP_SENT, ctre_pkg::OP_RESET, ctre_pkg::OP_DUP, ctre_pkg::OP_ARM: begin
        if (it.op == ctre_pkg::OP_RM_ADDR || it.op == ctre_pkg::OP_FIND)
          s = find_addr(it.remote_address);
        else s = tbl_valid[it.conn_index] ? int'(it.conn_index) : -1;
        if (s < 0) begin
          expect_result(result_of(ctre_pkg::ST_NOTFOUND, 0, 0, 0, 0, 1));
          return;
        end
        case (it.op)
          ctre_pkg::OP_RM_IDX, ctre_pkg::OP_RM_ADDR: tbl_valid[s] = 1'b0;
          ctre_pkg::OP_TOUCH: tbl[s].activity_time = it.time_ms;
          ctre_pkg::OP_SENT: begin
            if (tbl[s].retx_count != ctre_pkg::CNT_MAX) tbl[s].retx_count++;
            tbl[s].last_tx_time = '0;
            rc = tbl[s].retx_count;
          end
          ctre_pkg::OP_RESET: clear_retx(s);
          ctre_pkg::OP_DUP: begin
            if (tbl[s].last_rx_sequence == {1'b0, it.seq_number}) d = 1'b1;
            else tbl[s].last_rx_sequence = {1'b0, it.seq_number};
          end
          ctre_pkg::OP_ARM: begin
            tbl[s].retx_pending = 1'b1;
            tbl[s].last_tx_time = it.time_ms;
          end
          default: ;
        endcase
        expect_result(result_of(ctre_pkg::ST_OK, 3'(s), 1, d, rc, 1));
      end
      ctre_pkg::OP_IDLE_SW: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i] && (it.time_ms - tbl[i].activity_time) >= cfg_idle_to) begin
            tbl_valid[i] = 1'b0;
            expect_result(result_of(ctre_pkg::ST_OK, 3'(i), 1, 0, 0, 0));
          end
        end
        expect_result(result_of(ctre_pkg::ST_OK, 0, 0, 0, 0, 1));
      end
      ctre_pkg::OP_RETX_SW: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!tbl_valid[i] || !tbl[i].retx_pending) continue;
          if ((it.time_ms - tbl[i].last_tx_time) < tbl[i].retx_timeout) continue;
          if (tbl[i].retx_count < tbl[i].entry_retry_limit) begin
            dbl = {32'd0, tbl[i].retx_timeout} << 1;
            tbl[i].retx_timeout = (dbl <= {32'd0, cfg_max_rto}) ? dbl[31:0] : cfg_max_rto;
            expect_result(result_of(ctre_pkg::ST_OK, 3'(i), 1, 0, 0, 0));
          end else begin
            clear_retx(i);
          end
        end
        expect_result(result_of(ctre_pkg::ST_OK, 0, 0, 0, 0, 1));
      end
      default: expect_result(result_of(ctre_pkg::ST_NOTFOUND, 0, 0, 0, 0, 1));
    endcase
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_valid) void'(pending_items.pop_front());
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_valid <= 1'b1;
        in_item <= pending_items[0];
        if (burst_left > 0) burst_left <= burst_left - 1;
        else if (gaps_on) begin
          burst_left <= $urandom_range(12);
          gap_left <= $urandom_range(5);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (hold_off && !hold_done) begin
      out_stall <= 1'b1;
      hold_count <= hold_count + 1;
      if (hold_count >= HOLD_CYCLES - 1) hold_done <= 1'b1;
    end else if (stall_pattern_on) out_stall <= ($urandom_range(3) == 0);
    else out_stall <= 1'b0;
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) predict_table_op(in_item);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_item, '0);
        end else begin
          if (out_item.status !== expected_results[0].status)
            report_mismatch("status", out_item, expected_results[0]);
          else if (out_item.result_index !== expected_results[0].result_index)
            report_mismatch("result_index", out_item, expected_results[0]);
          else if (out_item.hit !== expected_results[0].hit)
            report_mismatch("hit", out_item, expected_results[0]);
          else if (out_item.duplicate !== expected_results[0].duplicate)
            report_mismatch("duplicate", out_item, expected_results[0]);
          else if (out_item.retry_count !== expected_results[0].retry_count)
            report_mismatch("retry_count", out_item, expected_results[0]);
          else if (out_item.last !== expected_results[0].last)
            report_mismatch("last", out_item, expected_results[0]);
          void'(expected_results.pop_front());
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (hold_off && !hold_done))
        watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("FAIL connection_table_retransmit_engine_top");
        $finish;
      end
    end
  end

  function automatic logic [15:0] pick_addr();
    if (known_addrs.size() > 0 && $urandom_range(3) != 0)
      return known_addrs[$urandom_range(known_addrs.size() - 1)];
    return 16'($urandom_range(1, 65535));
  endfunction

  function automatic ctre_pkg::in_item_t make_item(logic [3:0] op, logic [15:0] a,
                                                   logic [2:0] idx, logic [3:0] seq,
                                                   logic [7:0] lim, logic [31:0] t);
    ctre_pkg::in_item_t it;
    it.op = op;
    it.remote_address = a;
    it.conn_index = idx;
    it.seq_number = seq;
    it.retry_limit = lim;
    it.time_ms = t;
    return it;
  endfunction

  task automatic queue_item(ctre_pkg::in_item_t it);
    if (it.op == ctre_pkg::OP_CREATE && it.remote_address != 0)
      known_addrs.insert(known_addrs.size(), it.remote_address);
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    write_reg_model(idx, v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_phase(int n);
    logic [3:0] op;
    logic [31:0] t;
    for (int k = 0; k < n; k++) begin
      t = ($urandom_range(9) == 0) ? $urandom : $urandom_range(20000);
      case ($urandom_range(19))
        0, 1, 2, 3: op = ctre_pkg::OP_CREATE;
        4: op = ctre_pkg::OP_RM_IDX;
        5: op = ctre_pkg::OP_RM_ADDR;
        6: op = ctre_pkg::OP_FIND;
        7, 8: op = ctre_pkg::OP_TOUCH;
        9, 10: op = ctre_pkg::OP_SENT;
        11: op = ctre_pkg::OP_RESET;
        12, 13: op = ctre_pkg::OP_DUP;
        14, 15: op = ctre_pkg::OP_ARM;
        16: op = ctre_pkg::OP_IDLE_SW;
        17, 18: op = ctre_pkg::OP_RETX_SW;
        default: op = 4'($urandom_range(11, 15));
      endcase
      queue_item(make_item(op, ($urandom_range(15) == 0) ? 16'd0 : pick_addr(),
                           3'($urandom), 4'($urandom),
                           ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom), t));
    end
  endtask

  initial begin
    write_reg_model(ctre_pkg::REG_MAX_CONN, 32'd8);
    write_reg_model(ctre_pkg::REG_IDLE_TO, 32'd6000);
    write_reg_model(ctre_pkg::REG_INIT_RTO, 32'd3000);
    write_reg_model(ctre_pkg::REG_MAX_RTO, 32'd6000);
    for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
    next_slot = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every op, special cases
    queue_item(make_item(ctre_pkg::OP_CREATE, 16'd0, 0, 0, 0, 0));
    queue_item(make_item(ctre_pkg::OP_CREATE, 16'hFFFF, 7, 4'hF, 8'hFF, 32'hFFFFFFFF));
    queue_item(make_item(ctre_pkg::OP_CREATE, 16'hFFFF, 0, 0, 0, 0));
    queue_item(make_item(ctre_pkg::OP_CREATE, 16'h0001, 0, 4'h0, 8'd1, 0));
    queue_item(make_item(ctre_pkg::OP_FIND, 16'h0001, 0, 0, 0, 0));
    queue_item(make_item(ctre_pkg::OP_FIND, 16'h1234, 0, 0, 0, 0));
    queue_item(make_item(ctre_pkg::OP_DUP, 0, 3'd1, 4'hF, 0, 0));
    queue_item(make_item(ctre_pkg::OP_DUP, 0, 3'd1, 4'hF, 0, 0));
    queue_item(make_item(ctre_pkg::OP_SENT, 0, 3'd0, 0, 0, 0));
    queue_item(make_item(ctre_pkg::OP_ARM, 0, 3'd1, 0, 0, 32'd100));
    queue_item(make_item(ctre_pkg::OP_RETX_SW, 0, 0, 0, 0, 32'd5000));
    queue_item(make_item(ctre_pkg::OP_RETX_SW, 0, 0, 0, 0, 32'd20000));
    queue_item(make_item(ctre_pkg::OP_RESET, 0, 3'd1, 0, 0, 0));
    queue_item(make_item(ctre_pkg::OP_TOUCH, 0, 3'd0, 0, 0, 32'hFFFFFFFF));
    queue_item(make_item(ctre_pkg::OP_IDLE_SW, 0, 0, 0, 0, 32'd1000));
    queue_item(make_item(ctre_pkg::OP_RM_IDX, 0, 3'd7, 0, 0, 0));
    queue_item(make_item(ctre_pkg::OP_RM_ADDR, 16'h0001, 0, 0, 0, 0));
    queue_item(make_item(4'd11, 0, 0, 0, 0, 0));
    queue_item(make_item(4'd15, 16'hFFFF, 7, 4'hF, 8'hFF, 32'hFFFFFFFF));
    for (int i = 0; i < 5; i++)
      queue_item(make_item(ctre_pkg::OP_CREATE, 16'h0100 + 16'(i), 3'd0, 4'(i), 8'd2, 0));
    wait_drained();

    // repeated mark-sent on the entry with a retry limit of 255, then an idle sweep
    for (int i = 0; i < 4; i++) queue_item(make_item(ctre_pkg::OP_SENT, 0, 3'd0, 0, 0, 0));
    queue_item(make_item(ctre_pkg::OP_IDLE_SW, 0, 0, 0, 0, 32'd7000));

    // long receiver hold-off while the sender keeps offering
    random_phase(10);
    hold_off = 1;
    wait (hold_done);
    hold_off = 0;
    wait_drained();

    write_reg(ctre_pkg::REG_MAX_CONN, 32'd1);
    write_reg(ctre_pkg::REG_INIT_RTO, 32'hFFFFFFFF);
    write_reg(ctre_pkg::REG_MAX_RTO, 32'hFFFFFFFF);
    write_reg(ctre_pkg::REG_IDLE_TO, 32'd0);
    random_phase(40);
    wait_drained();

    write_reg(ctre_pkg::REG_MAX_CONN, 32'd0);
    write_reg(ctre_pkg::REG_INIT_RTO, 32'd0);
    write_reg(ctre_pkg::REG_MAX_RTO, 32'd0);
    write_reg(ctre_pkg::REG_IDLE_TO, 32'hFFFFFFFF);
    random_phase(30);
    wait_drained();

    write_reg(ctre_pkg::REG_MAX_CONN, 32'd15);
    write_reg(ctre_pkg::REG_INIT_RTO, 32'd500);
    write_reg(ctre_pkg::REG_MAX_RTO, 32'd4000);
    write_reg(ctre_pkg::REG_IDLE_TO, 32'd8000);
    gaps_on = 0;
    stall_pattern_on = 0;
    random_phase(40);
    wait_drained();
    gaps_on = 1;
    stall_pattern_on = 1;

    write_reg(ctre_pkg::REG_MAX_CONN, 32'd5);
    write_reg(ctre_pkg::REG_INIT_RTO, 32'd3000);
    write_reg(ctre_pkg::REG_MAX_RTO, 32'd6000);
    write_reg(ctre_pkg::REG_IDLE_TO, 32'd6000);
    random_phase(80);
    wait_drained();

    if (error_count == 0) $display("PASS connection_table_retransmit_engine_top");
    else $display("FAIL connection_table_retransmit_engine_top");
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
sv/ctre_pkg.sv
sv/connection_table_retransmit_engine_top.sv
sv/ctre_checker.sv
verif/tb.sv
